FILE: rtl/correlating_branch_predictor_assert.svh
// Assertion macros for the checker file of the branch predictor.
`ifndef CORRELATING_BRANCH_PREDICTOR_ASSERT_SVH
`define CORRELATING_BRANCH_PREDICTOR_ASSERT_SVH

// Plain property, checked at every rising edge outside reset.
`define CBP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent followed in the next cycle by a consequent.
`define CBP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error(msg);

`endif

FILE: rtl/cbp_pkg.sv
`default_nettype none

package cbp_pkg;

	localparam int ADDR_W        = 32;
	localparam int MAX_ADDR_BITS = 10;
	localparam int MAX_HIST_BITS = 4;
	localparam int IDX_W         = MAX_ADDR_BITS + MAX_HIST_BITS;
	localparam int DEPTH         = 1 << IDX_W;
	localparam int ABITS_W       = 4;
	localparam int HBITS_W       = 3;
	localparam int CFG_DATA_W    = 4;
	localparam int CFG_IDX_W     = 1;
	localparam int IN_TDATA_W    = 40;
	localparam int OUT_TDATA_W   = 8;

	typedef logic [1:0] ctr_t;
	localparam ctr_t CTR_RESET = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADDR_BITS = 1'b0,
		REG_HIST_BITS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             taken;
	} lookup_t;

	typedef struct packed {
		logic vld;
		logic pred;
		logic mispred;
	} result_t;

	function automatic ctr_t next_ctr(ctr_t c, logic t);
		ctr_t n;
		if (t) begin
			n = (c == 2'd0) ? 2'd1 : 2'd3;
		end else begin
			n = (c == 2'd3) ? 2'd2 : 2'd0;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cbp_hist.sv
`default_nettype none

module cbp_hist (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         acc,
	input  wire  [cbp_pkg::ADDR_W-1:0]  addr,
	input  wire                         taken,
	input  wire  [cbp_pkg::ABITS_W-1:0] addr_bits,
	input  wire  [cbp_pkg::HBITS_W-1:0] hist_bits,
	output cbp_pkg::lookup_t            look
);
	import cbp_pkg::*;

	logic [MAX_HIST_BITS-1:0] hist_q;
	logic [ABITS_W-1:0]       m;
	logic [HBITS_W-1:0]       k;
	logic [MAX_ADDR_BITS-1:0] row_mask;
	logic [MAX_HIST_BITS-1:0] col_mask;
	logic [MAX_ADDR_BITS-1:0] row;
	logic [MAX_HIST_BITS-1:0] col;
	logic [MAX_HIST_BITS-1:0] ins;
	logic [MAX_HIST_BITS-1:0] hist_nxt;

	always_comb begin
		m = (addr_bits > ABITS_W'(MAX_ADDR_BITS)) ? ABITS_W'(MAX_ADDR_BITS) : addr_bits;
		k = (hist_bits > HBITS_W'(MAX_HIST_BITS)) ? HBITS_W'(MAX_HIST_BITS) : hist_bits;
		row_mask = MAX_ADDR_BITS'(({{MAX_ADDR_BITS{1'b0}}, 1'b1} << m) - 1'b1);
		col_mask = MAX_HIST_BITS'(({{MAX_HIST_BITS{1'b0}}, 1'b1} << k) - 1'b1);
		row = addr[MAX_ADDR_BITS-1:0] & row_mask;
		col = hist_q & col_mask;
		ins = {{(MAX_HIST_BITS-1){1'b0}}, taken} << (k - 1'b1);
		hist_nxt = (col >> 1) | ins;
		look.vld = acc;
		look.idx = {row, col};
		look.taken = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '1;
		end else if (acc && (k != '0)) begin
			hist_q <= hist_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cbp_table.sv
`default_nettype none

module cbp_table (
	input  wire               clk,
	input  wire               arst_n,
	input  wire cbp_pkg::lookup_t look,
	input  wire               adv,
	output logic              ready,
	output cbp_pkg::result_t  res
);
	import cbp_pkg::*;

	ctr_t             mem [DEPTH];
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             taken_s1;
	ctr_t             rd_s1;
	logic             fw_vld_q;
	logic [IDX_W-1:0] fw_idx_q;
	ctr_t             fw_val_q;
	ctr_t             cur;
	ctr_t             nxt;
	logic             wr_s1;
	logic             we;
	logic [IDX_W-1:0] wa;
	ctr_t             wd;

	always_comb begin
		cur = (fw_vld_q && (fw_idx_q == idx_s1)) ? fw_val_q : rd_s1;
		nxt = next_ctr(cur, taken_s1);
		wr_s1 = v_s1 && adv;
		we = clr_q || wr_s1;
		wa = clr_q ? clr_idx_q : idx_s1;
		wd = clr_q ? CTR_RESET : nxt;
		ready = !clr_q && (!v_s1 || adv);
		res.vld = v_s1;
		res.pred = cur[1];
		res.mispred = cur[1] ^ taken_s1;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (look.vld) begin
			rd_s1 <= mem[look.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fw_vld_q <= 1'b0;
		end else begin
			if (look.vld) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (wr_s1) begin
				fw_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (look.vld) begin
			idx_s1 <= look.idx;
			taken_s1 <= look.taken;
		end
		if (wr_s1) begin
			fw_idx_q <= idx_s1;
			fw_val_q <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/correlating_branch_predictor.sv
`default_nettype none

// Correlating branch predictor with a table of 2-bit counters indexed by the
// low address bits and the global history. Each item gives a prediction and a
// mispredict flag, held in the table stage and then in the output register; a
// new item is taken every cycle while the output is not stalled. The counter
// table is a single-port-write memory read at accept and written when the item
// leaves the table stage, with the last write forwarded to a following read of
// the same entry. After reset the table is cleared to strongly taken in one pass
// of 16384 entries, while s_tready stays low and configuration writes are taken.
module correlating_branch_predictor (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: branch_address[31:0], taken[32], zero padding.
	input  wire  [cbp_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// Fields from bit 0: predicted_taken[0], mispredicted[1], zero padding.
	output logic [cbp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  wire                             cfg_we,
	input  wire  [cbp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire  [cbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cbp_pkg::*;

	logic [ABITS_W-1:0] abits_q;
	logic [HBITS_W-1:0] hbits_q;
	logic               acc;
	logic               adv;
	logic               out_vld_q;
	logic               pred_q;
	logic               mis_q;
	lookup_t            look;
	result_t            res;

	assign acc = s_tvalid && s_tready;
	assign adv = !out_vld_q || m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata = {{(OUT_TDATA_W-2){1'b0}}, mis_q, pred_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abits_q <= '0;
			hbits_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ADDR_BITS: abits_q <= cfg_data[ABITS_W-1:0];
				REG_HIST_BITS: hbits_q <= cfg_data[HBITS_W-1:0];
				default: ;
			endcase
		end
	end

	cbp_hist u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.addr      (s_tdata[ADDR_W-1:0]),
		.taken     (s_tdata[ADDR_W]),
		.addr_bits (abits_q),
		.hist_bits (hbits_q),
		.look      (look)
	);

	cbp_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.look   (look),
		.adv    (adv),
		.ready  (s_tready),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.vld) begin
			pred_q <= res.pred;
			mis_q <= res.mispred;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cbp_checker.sv
`default_nettype none

`include "correlating_branch_predictor_assert.svh"

module cbp_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tvalid,
	input wire                             s_tready,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [cbp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import cbp_pkg::*;

	`CBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
	`CBP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result item changed")
	`CBP_ASSERT(a_out_pad, m_tvalid |-> (m_tdata[OUT_TDATA_W-1:2] == '0), "result padding not zero")
	`CBP_ASSERT_NEXT(a_no_invent, !(s_tvalid && s_tready) ##1 !m_tvalid, !m_tvalid, "result item without an input item")

endmodule

bind correlating_branch_predictor cbp_checker u_cbp_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_correlating_branch_predictor.sv
`timescale 1ns / 100ps

module tb_correlating_branch_predictor;
	import cbp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_LIMIT = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 240;
	localparam int POOL = 8;
	localparam int DIRECTED_ROWS = 27;

	typedef struct packed {
		logic                  is_write;
		cfg_reg_t              sel;
		logic [CFG_DATA_W-1:0] value;
		logic [ADDR_W-1:0]     addr;
		logic                  taken;
		logic                  known;
		logic                  pred;
		logic                  mispred;
	} stim_row_t;

	typedef struct packed {
		logic pred;
		logic mispred;
	} outcome_t;

	// Rows with known set carry an outcome that follows from the reset state alone.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h1234_5678, 1'b1, 1'b1, 1'b0, 1'b1},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0},
		'{1'b1, REG_ADDR_BITS, 4'd10, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HIST_BITS, 4'd4,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_03FF, 1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'hFFFF_FC00, 1'b1, 1'b1, 1'b1, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_03FF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_03FF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_03FF, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_ADDR_BITS, 4'd15, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HIST_BITS, 4'd7,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_ADDR_BITS, 4'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HIST_BITS, 4'd1,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h5555_5555, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_ADDR_BITS, 4'd3,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HIST_BITS, 4'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_000F, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'h0000_0007, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ADDR_BITS, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	wire s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	wire m_tvalid;
	logic m_tready = 1'b0;
	wire [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_idx = REG_ADDR_BITS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic item_known = 1'b0;
	logic item_pred = 1'b0;
	logic item_mispred = 1'b0;
	bit steady = 1'b0;
	int cycles = 0;
	int errors = 0;

	ctr_t counters [DEPTH];
	logic [MAX_HIST_BITS-1:0] ghist;
	logic [ABITS_W-1:0] row_width;
	logic [HBITS_W-1:0] hist_width;
	outcome_t pending_outcomes [$];

	correlating_branch_predictor uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic outcome_t predict_branch(logic [ADDR_W-1:0] addr, logic taken);
		int m;
		int k;
		logic [IDX_W-1:0] slot;
		ctr_t c;
		outcome_t o;
		m = (row_width > MAX_ADDR_BITS) ? MAX_ADDR_BITS : int'(row_width);
		k = (hist_width > MAX_HIST_BITS) ? MAX_HIST_BITS : int'(hist_width);
		slot = IDX_W'(((addr & ((32'd1 << m) - 32'd1)) << MAX_HIST_BITS)
			| (int'(ghist) & ((1 << k) - 1)));
		c = counters[slot];
		o.pred = c[1];
		o.mispred = c[1] ^ taken;
		if (taken) begin
			counters[slot] = (c == 2'd0) ? 2'd1 : 2'd3;
		end else begin
			counters[slot] = (c == 2'd3) ? 2'd2 : 2'd0;
		end
		if (k > 0) begin
			ghist = MAX_HIST_BITS'(((int'(ghist) & ((1 << k) - 1)) >> 1)
				| (int'(taken) << (k - 1)));
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			foreach (counters[i]) counters[i] = CTR_RESET;
			ghist = '1;
			row_width = '0;
			hist_width = '0;
			pending_outcomes.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ADDR_BITS: row_width = cfg_data;
					REG_HIST_BITS: hist_width = cfg_data[HBITS_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = predict_branch(s_tdata[ADDR_W-1:0], s_tdata[ADDR_W]);
				if (item_known) begin
					want = {item_pred, item_mispred};
				end
				pending_outcomes.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.pred = m_tdata[0];
				got.mispred = m_tdata[1];
				if (pending_outcomes.size() == 0) begin
					errors++;
					if (errors <= PRINT_LIMIT) begin
						$display("%0t: unexpected item, expected none, got %b", $time, got);
					end
				end else begin
					want = pending_outcomes.pop_front();
					if (got.pred !== want.pred) begin
						errors++;
						if (errors <= PRINT_LIMIT) begin
							$display("%0t: predicted_taken expected %b, got %b",
								$time, want.pred, got.pred);
						end
					end
					if (got.mispred !== want.mispred) begin
						errors++;
						if (errors <= PRINT_LIMIT) begin
							$display("%0t: mispredicted expected %b, got %b",
								$time, want.mispred, got.mispred);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_branch(logic [ADDR_W-1:0] addr, logic taken, logic known,
		logic pred, logic mispred);
		int gap;
		if (!steady && $urandom_range(99) < 15) begin
			gap = $urandom_range(4, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, taken, addr};
		item_known <= known;
		item_pred <= pred;
		item_mispred <= mispred;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_outcomes();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
		drain_outcomes();
		cfg_we <= 1'b1;
		cfg_idx <= sel;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [ADDR_W-1:0] pool_addr [POOL];
		int pool_period [POOL];
		int pool_step [POOL];
		logic [ADDR_W-1:0] addr;
		logic taken;
		logic [CFG_DATA_W-1:0] abits;
		logic [CFG_DATA_W-1:0] hbits;
		int j;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].is_write) begin
				write_register(DIRECTED[r].sel, DIRECTED[r].value);
			end else begin
				send_branch(DIRECTED[r].addr, DIRECTED[r].taken, DIRECTED[r].known,
					DIRECTED[r].pred, DIRECTED[r].mispred);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin abits = 4'd10; hbits = 4'd4; end
				1: begin abits = 4'd0; hbits = 4'd0; end
				2: begin abits = 4'd15; hbits = 4'd7; end
				default: begin
					abits = 4'($urandom_range(15));
					hbits = 4'($urandom_range(7));
				end
			endcase
			write_register(REG_ADDR_BITS, abits);
			write_register(REG_HIST_BITS, hbits);
			steady <= (phase == 3);
			for (int i = 0; i < POOL; i++) begin
				pool_addr[i] = $urandom;
				pool_period[i] = $urandom_range(6, 2);
				pool_step[i] = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 75) begin
					j = $urandom_range(POOL - 1);
					addr = pool_addr[j];
					taken = (pool_step[j] % pool_period[j]) != 0;
					pool_step[j]++;
					if ($urandom_range(99) < 5) begin
						taken = ~taken;
					end
				end else begin
					addr = $urandom;
					taken = 1'($urandom_range(1));
				end
				send_branch(addr, taken, 1'b0, 1'b0, 1'b0);
			end
		end

		drain_outcomes();
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/cbp_pkg.sv
rtl/cbp_hist.sv
rtl/cbp_table.sv
rtl/correlating_branch_predictor.sv
rtl/cbp_checker.sv
tb/sv/tb_correlating_branch_predictor.sv
